FILE: rtl/apc2_pkg.sv
package apc2_pkg;

    // Channel count; channels at or above it carry no state
    localparam int NUM_CHANNELS = 16;

    // Field and arithmetic widths
    localparam int SMP_W  = 24;
    localparam int CH_W   = 4;
    localparam int COEF_W = 16;
    localparam int FRAC_W = 15;
    localparam int DIFF_W = SMP_W + 1;
    localparam int PROD_W = DIFF_W + COEF_W;
    localparam int RND_W  = PROD_W - FRAC_W;
    localparam int SUM_W  = RND_W + 1;

    // Only channels reachable by the channel field need storage
    localparam int STORE_DEPTH = (NUM_CHANNELS < (2 ** CH_W)) ? NUM_CHANNELS : (2 ** CH_W);
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    // Register indexes on the configuration port
    localparam logic REG_COEF_FIRST  = 1'b0;
    localparam logic REG_COEF_SECOND = 1'b1;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL1 = 5'b00010,
        ST_ADD1 = 5'b00100,
        ST_MUL2 = 5'b01000,
        ST_WB   = 5'b10000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic mul1;
        logic add1;
        logic mul2;
        logic wb;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Saturate a widened sum to the sample range
    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SUM_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > SUM_W'(SMP_MAX))
            r = SMP_MAX;
        else if (v < SUM_W'(SMP_MIN))
            r = SMP_MIN;
        else
            r = v[SMP_W-1:0];
        return r;
    endfunction

    // Q1.15 product to integer, round half up (add half, floor)
    function automatic logic signed [RND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(1 << (FRAC_W - 1));
        return t[PROD_W-1:FRAC_W];
    endfunction

endpackage

FILE: rtl/apc2_ctrl.sv
module apc2_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  apc2_pkg::dp_status_t status,
    output apc2_pkg::dp_cmd_t    cmd
);

    apc2_pkg::state_t state_reg;
    apc2_pkg::state_t state_next;

    // Item taken only between items
    assign s_tready = (state_reg == apc2_pkg::ST_IDLE);

    // Commands follow the state; write-back waits for a free output register
    always_comb
    begin
        cmd      = '0;
        cmd.load = s_tready && s_tvalid;
        cmd.mul1 = (state_reg == apc2_pkg::ST_MUL1);
        cmd.add1 = (state_reg == apc2_pkg::ST_ADD1);
        cmd.mul2 = (state_reg == apc2_pkg::ST_MUL2);
        cmd.wb   = (state_reg == apc2_pkg::ST_WB) && status.out_free;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            apc2_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = apc2_pkg::ST_MUL1;
            end
            apc2_pkg::ST_MUL1: state_next = apc2_pkg::ST_ADD1;
            apc2_pkg::ST_ADD1: state_next = apc2_pkg::ST_MUL2;
            apc2_pkg::ST_MUL2: state_next = apc2_pkg::ST_WB;
            apc2_pkg::ST_WB:
            begin
                if (status.out_free)
                    state_next = apc2_pkg::ST_IDLE;
            end
            default: state_next = apc2_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= apc2_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: rtl/apc2_datapath.sv
module apc2_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  apc2_pkg::dp_cmd_t                    cmd,
    output apc2_pkg::dp_status_t                 status,
    input  logic signed [apc2_pkg::COEF_W-1:0]   coef_first,
    input  logic signed [apc2_pkg::COEF_W-1:0]   coef_second,
    input  logic signed [apc2_pkg::SMP_W-1:0]    sample_in,
    input  logic        [apc2_pkg::CH_W-1:0]     channel,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [apc2_pkg::SMP_W-1:0]    sample_out,
    output logic        [apc2_pkg::CH_W-1:0]     channel_out
);

    // Per-channel state: previous input, intermediate value, previous output
    logic signed [apc2_pkg::SMP_W-1:0] x1_mem_reg [apc2_pkg::STORE_DEPTH];
    logic signed [apc2_pkg::SMP_W-1:0] d2_mem_reg [apc2_pkg::STORE_DEPTH];
    logic signed [apc2_pkg::SMP_W-1:0] y1_mem_reg [apc2_pkg::STORE_DEPTH];

    // Working registers of the item in flight
    logic signed [apc2_pkg::SMP_W-1:0]  x_reg;
    logic signed [apc2_pkg::SMP_W-1:0]  x1_reg;
    logic signed [apc2_pkg::SMP_W-1:0]  d2_reg;
    logic signed [apc2_pkg::SMP_W-1:0]  y1_reg;
    logic signed [apc2_pkg::SMP_W-1:0]  p_reg;
    logic signed [apc2_pkg::DIFF_W-1:0] diff_reg;
    logic signed [apc2_pkg::PROD_W-1:0] prod_reg;
    logic        [apc2_pkg::CH_W-1:0]   ch_reg;
    logic                               ch_ok_reg;

    // Output register
    logic                               out_valid_reg;
    logic                               out_valid_next;
    logic signed [apc2_pkg::SMP_W-1:0]  out_smp_reg;
    logic        [apc2_pkg::CH_W-1:0]   out_ch_reg;

    logic                               ch_ok;
    logic        [apc2_pkg::ADDR_W-1:0] rd_idx;
    logic        [apc2_pkg::ADDR_W-1:0] wr_idx;
    logic signed [apc2_pkg::SMP_W-1:0]  x1_rd;
    logic signed [apc2_pkg::SMP_W-1:0]  d2_rd;
    logic signed [apc2_pkg::SMP_W-1:0]  y1_rd;
    logic signed [apc2_pkg::DIFF_W-1:0] diff2;
    logic signed [apc2_pkg::COEF_W-1:0] coef_sel;
    logic signed [apc2_pkg::DIFF_W-1:0] mul_in;
    logic signed [apc2_pkg::SMP_W-1:0]  sum_base;
    logic signed [apc2_pkg::SMP_W-1:0]  sum_sat;

    // State lookup for the incoming channel
    assign ch_ok  = (32'(channel) < apc2_pkg::NUM_CHANNELS);
    assign rd_idx = channel[apc2_pkg::ADDR_W-1:0];
    assign wr_idx = ch_reg[apc2_pkg::ADDR_W-1:0];
    assign x1_rd  = ch_ok ? x1_mem_reg[rd_idx] : '0;
    assign d2_rd  = ch_ok ? d2_mem_reg[rd_idx] : '0;
    assign y1_rd  = ch_ok ? y1_mem_reg[rd_idx] : '0;

    // One shared multiplier: first section, then second section
    assign diff2    = apc2_pkg::DIFF_W'(p_reg) - apc2_pkg::DIFF_W'(y1_reg);
    assign coef_sel = cmd.mul2 ? coef_second : coef_first;
    assign mul_in   = cmd.mul2 ? diff2 : diff_reg;

    // One shared rounding adder with saturation: p in ADD1, y in WB
    assign sum_base = cmd.add1 ? x1_reg : d2_reg;
    assign sum_sat  = apc2_pkg::sat_smp(apc2_pkg::SUM_W'(sum_base)
                      + apc2_pkg::SUM_W'(apc2_pkg::round_q15(prod_reg)));

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg     <= sample_in;
            ch_reg    <= channel;
            ch_ok_reg <= ch_ok;
            x1_reg    <= x1_rd;
            d2_reg    <= d2_rd;
            y1_reg    <= y1_rd;
            diff_reg  <= apc2_pkg::DIFF_W'(sample_in) - apc2_pkg::DIFF_W'(d2_rd);
        end
        if (cmd.mul1 || cmd.mul2)
            prod_reg <= apc2_pkg::PROD_W'(coef_sel) * apc2_pkg::PROD_W'(mul_in);
        if (cmd.add1)
            p_reg <= sum_sat;
        if (cmd.wb)
        begin
            out_smp_reg <= ch_ok_reg ? sum_sat : '0;
            out_ch_reg  <= ch_reg;
        end
    end

    // Channel state, cleared at reset, updated on write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < apc2_pkg::STORE_DEPTH; i++)
            begin
                x1_mem_reg[i] <= '0;
                d2_mem_reg[i] <= '0;
                y1_mem_reg[i] <= '0;
            end
        end
        else if (cmd.wb && ch_ok_reg)
        begin
            x1_mem_reg[wr_idx] <= x_reg;
            d2_mem_reg[wr_idx] <= p_reg;
            y1_mem_reg[wr_idx] <= sum_sat;
        end
    end

    // Output item valid
    always_comb
    begin
        if (cmd.wb)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign sample_out      = out_smp_reg;
    assign channel_out     = out_ch_reg;

endmodule

FILE: rtl/allpass_first_order_cascade2_unit.sv
// Two cascaded first-order allpass sections per channel (16 channels), signed 24-bit
// samples, Q1.15 coefficients set over the APB port (coef_first at 0x0, coef_second at
// 0x4). One item is taken at a time. The channel state is read in the accept cycle
// itself. Then come a multiply, a round-add-saturate that gives the intermediate value,
// a second multiply and a write-back into the output register. The single shared
// multiplier and the dependency of the second section on the first make these steps
// run one after another. The next item is taken the cycle after write-back, so no new
// item enters before the last one is through. A result still waiting downstream holds
// write-back until it has gone. Channel state lives in flip-flops cleared by reset, so
// the block is ready straight after reset.
module allpass_first_order_cascade2_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [23:0] sample_in, [27:24] channel, [31:28] zero
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [23:0] sample_out, [27:24] channel_out, [31:28] zero
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [apc2_pkg::COEF_W-1:0] coef_first_reg;
    logic signed [apc2_pkg::COEF_W-1:0] coef_second_reg;
    logic                               cfg_wr;
    logic signed [apc2_pkg::SMP_W-1:0]  sample_out;
    logic        [apc2_pkg::CH_W-1:0]   channel_out;
    apc2_pkg::dp_cmd_t                  cmd;
    apc2_pkg::dp_status_t               status;

    // Coefficient registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_first_reg  <= '0;
            coef_second_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                apc2_pkg::REG_COEF_FIRST:  coef_first_reg  <= pwdata[apc2_pkg::COEF_W-1:0];
                apc2_pkg::REG_COEF_SECOND: coef_second_reg <= pwdata[apc2_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back, sign-extended
    always_comb
    begin
        case (paddr[2])
            apc2_pkg::REG_COEF_FIRST:  prdata = 32'(coef_first_reg);
            apc2_pkg::REG_COEF_SECOND: prdata = 32'(coef_second_reg);
            default:                   prdata = '0;
        endcase
    end

    apc2_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    apc2_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .coef_first  (coef_first_reg),
        .coef_second (coef_second_reg),
        .sample_in   (s_tdata[apc2_pkg::SMP_W-1:0]),
        .channel     (s_tdata[apc2_pkg::SMP_W +: apc2_pkg::CH_W]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .sample_out  (sample_out),
        .channel_out (channel_out)
    );

    assign m_tdata = {4'b0000, channel_out, sample_out};

    // Checks
    a_cmd_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul1, cmd.add1, cmd.mul2, cmd.wb}))
        else $error("more than one datapath command at once");

    a_wb_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |-> (!m_tvalid || m_tready))
        else $error("write-back over a result not yet taken");

    a_wb_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wb |=> m_tvalid)
        else $error("write-back did not present a result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !s_tready ##3 !s_tready)
        else $error("new item taken while one is in flight");

endmodule
